@@ sv/bpsr_pkg.sv @@
// ----------------------------------------------------------------------------
// bpsr_pkg: shared types and constants for the byte pattern search/replace
// Register indexes, fixed field widths and the output buffer control word.
// ----------------------------------------------------------------------------
package bpsr_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 5;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int TOTAL_W    = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_HIGH   = 3'd4;

  localparam logic [LEN_W-1:0]   PATTERN_LENGTH_RST = 5'd1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX          = '1;

  typedef logic [BYTE_W-1:0] byte_t;

  // output buffer control, one word shared by every buffer cell
  typedef struct packed {
    logic load;      // take a fresh batch of results
    logic pop;       // head beat taken, move toward the head
    logic is_match;  // batch starts with the replacement sequence
  } ob_ctl_t;

endpackage

@@ sv/bpsr_win_cell.sv @@
// ----------------------------------------------------------------------------
// bpsr_win_cell: one byte of the pending window
// Holds one byte, takes its neighbor's byte on every accepted beat and
// checks the incoming byte against the pattern byte at its window position.
// ----------------------------------------------------------------------------
module bpsr_win_cell #(
  parameter int N   = 16,
  parameter int POS = 0
) (
  input  logic                       clk,
  input  logic                       shift,
  input  bpsr_pkg::byte_t            byte_in,
  input  logic [$clog2(N+1)-1:0]     fill_new,
  input  logic [$clog2(N+1)-1:0]     eff_len,
  input  bpsr_pkg::byte_t [N-1:0]    pattern,
  output bpsr_pkg::byte_t            byte_q,
  output logic                       ok
);
  import bpsr_pkg::*;

  localparam int FW = $clog2(N+1);
  localparam int IW = (N > 1) ? $clog2(N) : 1;
  localparam logic [FW:0] POS_V = (FW+1)'(POS);

  byte_t           byte_r;
  logic [FW:0]     fill_ext;
  logic            in_range;
  logic [FW-1:0]   pat_pos;
  logic [IW-1:0]   pat_idx;

  // the cell sits among the oldest eff_len bytes once the beat lands
  assign fill_ext = {1'b0, fill_new};
  assign in_range = (POS_V < fill_ext) && (fill_ext <= POS_V + {1'b0, eff_len});

  // oldest byte maps to pattern byte 0
  assign pat_pos = fill_new - FW'(POS) - FW'(1);
  assign pat_idx = pat_pos[IW-1:0];

  assign ok = !in_range || (byte_in == pattern[pat_idx]);

  // advance the window by one on every accepted beat
  always_ff @(posedge clk) begin
    if (shift) begin
      byte_r <= byte_in;
    end
  end

  assign byte_q = byte_r;

endmodule

@@ sv/bpsr_out_cell.sv @@
// ----------------------------------------------------------------------------
// bpsr_out_cell: one slot of the result buffer
// Loads its result of a fresh batch (replacement or window byte) and moves
// toward the head by one slot on every taken result beat.
// ----------------------------------------------------------------------------
module bpsr_out_cell #(
  parameter int N   = 16,
  parameter int POS = 0
) (
  input  logic                       clk,
  input  bpsr_pkg::ob_ctl_t          ctl,
  input  logic [$clog2(N+1)-1:0]     fill_new,
  input  logic [$clog2(N+1)-1:0]     eff_len,
  input  bpsr_pkg::byte_t            repl_byte,
  input  bpsr_pkg::byte_t [N-1:0]    win_next,
  input  bpsr_pkg::byte_t            nb_byte,
  input  logic                       nb_rep,
  output bpsr_pkg::byte_t            byte_q,
  output logic                       rep_q
);
  import bpsr_pkg::*;

  localparam int FW = $clog2(N+1);
  localparam int IW = (N > 1) ? $clog2(N) : 1;
  localparam logic [FW-1:0] POS_V = FW'(POS);

  byte_t          byte_r;
  logic           rep_r;
  byte_t          load_byte;
  logic           load_rep;
  logic [FW-1:0]  win_pos;
  logic [IW-1:0]  win_idx;

  // window position POS sits in cell fill_new-1-POS, newest in cell 0
  assign win_pos = fill_new - POS_V - FW'(1);
  assign win_idx = win_pos[IW-1:0];

  // pick the result for this slot of the new batch
  always_comb begin
    load_byte = '0;
    load_rep  = 1'b0;
    if (ctl.is_match && (POS_V < eff_len)) begin
      load_byte = repl_byte;
      load_rep  = 1'b1;
    end else if (POS_V < fill_new) begin
      load_byte = win_next[win_idx];
    end
  end

  // load a batch or move toward the head
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      byte_r <= load_byte;
      rep_r  <= load_rep;
    end else if (ctl.pop) begin
      byte_r <= nb_byte;
      rep_r  <= nb_rep;
    end
  end

  assign byte_q = byte_r;
  assign rep_q  = rep_r;

endmodule

@@ sv/byte_pattern_search_replace.sv @@
// ----------------------------------------------------------------------------
// byte_pattern_search_replace: fixed-pattern byte search and replace
// Rewrites a byte stream, swapping each non-overlapping occurrence of the
// configured search sequence for the replacement sequence.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle as long as each byte yields at most one
// result and the output does not stall, which is the steady state. A byte that
// yields n results (a match of length n, or a flush on the last byte) holds the
// input until they have left: results leave a buffer one beat per cycle unless
// out_stall holds them, and the next input beat is taken in the cycle the last
// result of the previous one is taken. The window is a row of byte cells, the
// newest byte entering the first cell; a match or a slide only lowers the fill
// count, so no byte ever moves by more than one cell. There is no clearing
// pass after reset. Write the configuration only while the block is idle.
module byte_pattern_search_replace #(
  parameter int MAX_PATTERN_BYTES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [bpsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpsr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bpsr_pkg::BYTE_W-1:0]       in_byte,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bpsr_pkg::BYTE_W-1:0]       out_byte,
  output logic                              out_was_replaced,
  output logic                              out_last,
  output logic [bpsr_pkg::TOTAL_W-1:0]      out_match_total
);
  import bpsr_pkg::*;

  localparam int N  = MAX_PATTERN_BYTES;
  localparam int FW = $clog2(N+1);

  // configuration
  logic [LEN_W-1:0]      pat_len_r;
  logic [CFG_DATA_W-1:0] pat_lo_r;
  logic [CFG_DATA_W-1:0] pat_hi_r;
  logic [CFG_DATA_W-1:0] rep_lo_r;
  logic [CFG_DATA_W-1:0] rep_hi_r;

  logic [2*CFG_DATA_W-1:0] pat_all;
  logic [2*CFG_DATA_W-1:0] rep_all;

  byte_t [N-1:0] pattern;
  byte_t [N-1:0] replace;
  logic [FW-1:0] eff_len;

  // window and result buffer
  logic [FW-1:0]      fill_r;
  logic [FW-1:0]      fill_nxt;
  logic [FW-1:0]      fill_new;
  logic [FW-1:0]      cnt_r;
  logic [FW-1:0]      cnt_nxt;
  logic [FW-1:0]      batch_cnt;
  logic [TOTAL_W-1:0] match_cnt_r;
  logic [TOTAL_W-1:0] match_cnt_nxt;

  byte_t [N-1:0] win_in;
  byte_t [N-1:0] win_q;
  logic  [N-1:0] ok;
  byte_t [N-1:0] ob_byte;
  logic  [N-1:0] ob_rep;
  byte_t [N-1:0] ob_nb_byte;
  logic  [N-1:0] ob_nb_rep;

  logic    accept;
  logic    pop;
  logic    emit_any;
  logic    is_match;
  ob_ctl_t ob_ctl;

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r <= PATTERN_LENGTH_RST;
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      rep_lo_r  <= '0;
      rep_hi_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pat_len_r <= cfg_data[LEN_W-1:0];
        REG_PATTERN_LOW:    pat_lo_r  <= cfg_data;
        REG_PATTERN_HIGH:   pat_hi_r  <= cfg_data;
        REG_REPLACE_LOW:    rep_lo_r  <= cfg_data;
        REG_REPLACE_HIGH:   rep_hi_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack search and replacement bytes
  assign pat_all = {pat_hi_r, pat_lo_r};
  assign rep_all = {rep_hi_r, rep_lo_r};

  for (genvar k = 0; k < N; k++) begin : g_unpack
    assign pattern[k] = pat_all[BYTE_W*k +: BYTE_W];
    assign replace[k] = rep_all[BYTE_W*k +: BYTE_W];
  end

  // clamp the length into 1..N
  always_comb begin
    if (pat_len_r == '0) begin
      eff_len = FW'(1);
    end else if (pat_len_r > LEN_W'(N)) begin
      eff_len = FW'(N);
    end else begin
      eff_len = pat_len_r[FW-1:0];
    end
  end

  // handshakes: take a beat once the buffer drains this cycle
  assign pop       = out_valid && !out_stall;
  assign in_stall  = (cnt_r > FW'(1)) || ((cnt_r == FW'(1)) && out_stall);
  assign accept    = in_valid && !in_stall;

  // window cells, newest byte in cell 0
  for (genvar j = 0; j < N; j++) begin : g_win
    if (j == 0) begin : g_head
      assign win_in[j] = in_byte;
    end else begin : g_body
      assign win_in[j] = win_q[j-1];
    end

    bpsr_win_cell #(
      .N   (N),
      .POS (j)
    ) u_cell (
      .clk      (clk),
      .shift    (accept),
      .byte_in  (win_in[j]),
      .fill_new (fill_new),
      .eff_len  (eff_len),
      .pattern  (pattern),
      .byte_q   (win_q[j]),
      .ok       (ok[j])
    );
  end

  // compare and decide on the beat
  assign fill_new = fill_r + FW'(1);
  assign emit_any = (fill_new >= eff_len);
  assign is_match = emit_any && (&ok);

  always_comb begin
    if (in_last) begin
      batch_cnt = fill_new;
      fill_nxt  = '0;
    end else if (is_match) begin
      batch_cnt = eff_len;
      fill_nxt  = fill_new - eff_len;
    end else if (emit_any) begin
      batch_cnt = FW'(1);
      fill_nxt  = fill_new - FW'(1);
    end else begin
      batch_cnt = '0;
      fill_nxt  = fill_new;
    end
  end

  // saturating match count
  always_comb begin
    match_cnt_nxt = match_cnt_r;
    if (accept && is_match && (match_cnt_r != TOTAL_MAX)) begin
      match_cnt_nxt = match_cnt_r + TOTAL_W'(1);
    end
  end

  // buffer fill count
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = batch_cnt;
    end else if (pop) begin
      cnt_nxt = cnt_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      cnt_r       <= '0;
      match_cnt_r <= '0;
    end else begin
      if (accept) begin
        fill_r <= fill_nxt;
      end
      cnt_r       <= cnt_nxt;
      match_cnt_r <= match_cnt_nxt;
    end
  end

  // result buffer cells, head in cell 0
  assign ob_ctl.load     = accept;
  assign ob_ctl.pop      = pop;
  assign ob_ctl.is_match = is_match;

  for (genvar k = 0; k < N; k++) begin : g_ob
    if (k == N-1) begin : g_tail
      assign ob_nb_byte[k] = '0;
      assign ob_nb_rep[k]  = 1'b0;
    end else begin : g_body
      assign ob_nb_byte[k] = ob_byte[k+1];
      assign ob_nb_rep[k]  = ob_rep[k+1];
    end

    bpsr_out_cell #(
      .N   (N),
      .POS (k)
    ) u_cell (
      .clk       (clk),
      .ctl       (ob_ctl),
      .fill_new  (fill_new),
      .eff_len   (eff_len),
      .repl_byte (replace[k]),
      .win_next  (win_in),
      .nb_byte   (ob_nb_byte[k]),
      .nb_rep    (ob_nb_rep[k]),
      .byte_q    (ob_byte[k]),
      .rep_q     (ob_rep[k])
    );
  end

  // the buffer holds one batch; the match total is a running, saturating count
  assign out_valid        = (cnt_r != '0);
  assign out_byte         = ob_byte[0];
  assign out_was_replaced = ob_rep[0];
  assign out_last         = (cnt_r == FW'(1));
  assign out_match_total  = match_cnt_r;

  // window never keeps a full row between beats
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(N-1))
    else $error("window holds too many pending bytes");

  // count holds while a batch is still draining
  a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > FW'(1)) |=> $stable(match_cnt_r))
    else $error("match total changed during a batch");

  // last beat empties the window
  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> (fill_r == '0))
    else $error("window not flushed on last beat");

  // a match always puts a replacement byte at the head
  a_match_head: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_match) |=> (out_valid && out_was_replaced))
    else $error("match without replacement at head");

endmodule
